>>> hw/rtl/ubf_pkg.sv
// shared types, constants and the overflow notice table for the serial bridge rings
`default_nettype none

package ubf_pkg;

    // ring geometry
    localparam int DEPTH      = 512;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int NOTICE_LEN = 19;
    localparam int NOTICE_W   = 5;
    localparam int COUNT_W    = 9;

    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [NOTICE_W-1:0] notice_idx_t;
    typedef logic [COUNT_W-1:0]  count_t;

    // item opcodes
    typedef enum logic [1:0] {
        OP_LINE_RX  = 2'd0,
        OP_HOST_WR  = 2'd1,
        OP_HOST_RD  = 2'd2,
        OP_LINE_RDY = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NOTICE,
        ST_DONE
    } state_t;

    // input item
    typedef struct packed {
        op_t        opcode;
        logic [7:0] data_in;
        logic       last_in;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [7:0] data_out;
        logic       data_valid;
        logic       accepted;
        logic       last_out;
        logic       tx_enabled;
        count_t     rx_used;
        count_t     tx_free;
    } out_item_t;

    // controls into one ring
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_data;
        logic       rd_en;
    } ring_ctrl_t;

    // status out of one ring
    typedef struct packed {
        ptr_t       used;
        ptr_t       free;
        logic [7:0] rd_data;
    } ring_stat_t;

    // overflow notice text, padded with newlines
    function automatic logic [7:0] notice_byte(input notice_idx_t idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'h3C;
            5'd1:    b = 8'h44;
            5'd2:    b = 8'h41;
            5'd3:    b = 8'h50;
            5'd4:    b = 8'h4C;
            5'd5:    b = 8'h69;
            5'd6:    b = 8'h6E;
            5'd7:    b = 8'h6B;
            5'd8:    b = 8'h3A;
            5'd9:    b = 8'h4F;
            5'd10:   b = 8'h76;
            5'd11:   b = 8'h65;
            5'd12:   b = 8'h72;
            5'd13:   b = 8'h66;
            5'd14:   b = 8'h6C;
            5'd15:   b = 8'h6F;
            5'd16:   b = 8'h77;
            5'd17:   b = 8'h3E;
            default: b = 8'h0A;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ubf_ring.sv
// one byte ring: storage, head and tail pointers and fill count
`default_nettype none

module ubf_ring (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ubf_pkg::ring_ctrl_t ctrl,
    output ubf_pkg::ring_stat_t      stat
);

    localparam ubf_pkg::ptr_t LAST_PTR = ubf_pkg::PTR_W'(ubf_pkg::DEPTH - 1);

    logic [7:0]    mem [ubf_pkg::DEPTH];
    ubf_pkg::ptr_t head_reg, head_next;
    ubf_pkg::ptr_t tail_reg, tail_next;
    ubf_pkg::ptr_t used_reg, used_next;
    logic [7:0]    rd_data_reg;

    // pointer advance with wrap
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        used_next = used_reg;
        if (ctrl.wr_en) begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
        end
        if (ctrl.rd_en) begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
        end
        case ({ctrl.wr_en, ctrl.rd_en})
            2'b10:   used_next = used_reg + 1'b1;
            2'b01:   used_next = used_reg - 1'b1;
            default: used_next = used_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            used_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            used_reg <= used_next;
        end
    end

    // storage write and registered pop read
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[head_reg] <= ctrl.wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[tail_reg];
        end
    end

    assign stat.used    = used_reg;
    assign stat.free    = LAST_PTR - used_reg;
    assign stat.rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/uart_bridge_fifos_overflow_marker_core.sv
// top level: serial line / host bridge with receive and transmit rings
`default_nettype none

// Bridge between a serial line and a host through two byte rings of DEPTH
// places, each holding up to DEPTH-1 bytes. One item is handled at a time.
// An ordinary item passes from its transfer in to its result being offered
// through the acceptance cycle, in which the ring is written or popped, and
// ST_DONE, which loads the result register (a pop's byte comes from the
// ring's registered read port). A received line byte that hits exactly
// NOTICE_LEN free places writes the overflow notice through the receive
// ring's single write port, one byte a cycle.
// The next item is taken once the result has been transferred out, or in
// the same cycle as that transfer. Rings start empty after reset; no
// clearing pass is needed.
module uart_bridge_fifos_overflow_marker_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ubf_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ubf_pkg::out_item_t     m_data
);

    localparam ubf_pkg::ptr_t NOTICE_FREE = ubf_pkg::PTR_W'(ubf_pkg::NOTICE_LEN);
    localparam ubf_pkg::notice_idx_t NOTICE_END =
        ubf_pkg::NOTICE_W'(ubf_pkg::NOTICE_LEN - 1);

    ubf_pkg::state_t      state_reg, state_next;
    ubf_pkg::op_t         op_reg, op_next;
    logic                 last_reg, last_next;
    logic                 acc_reg, acc_next;
    logic                 pop_reg, pop_next;
    logic                 tx_on_reg, tx_on_next;
    ubf_pkg::notice_idx_t cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;
    ubf_pkg::out_item_t   m_data_reg, m_data_next;

    ubf_pkg::ring_ctrl_t  rx_ctrl, tx_ctrl;
    ubf_pkg::ring_stat_t  rx_stat, tx_stat;
    logic                 in_xfer;

    ubf_ring u_rx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rx_ctrl),
        .stat    (rx_stat)
    );

    ubf_ring u_tx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tx_ctrl),
        .stat    (tx_stat)
    );

    assign s_ready = (state_reg == ubf_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign in_xfer = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // sequencer: next state, ring controls and result loading
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        last_next    = last_reg;
        acc_next     = acc_reg;
        pop_next     = pop_reg;
        tx_on_next   = tx_on_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rx_ctrl      = '{wr_en: 1'b0, wr_data: s_data.data_in, rd_en: 1'b0};
        tx_ctrl      = '{wr_en: 1'b0, wr_data: s_data.data_in, rd_en: 1'b0};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ubf_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    op_next    = s_data.opcode;
                    last_next  = s_data.last_in;
                    acc_next   = 1'b0;
                    pop_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ubf_pkg::ST_DONE;
                    case (s_data.opcode)
                        ubf_pkg::OP_LINE_RX: begin
                            if (rx_stat.free > NOTICE_FREE) begin
                                rx_ctrl.wr_en = 1'b1;
                                acc_next      = 1'b1;
                            end else if (rx_stat.free == NOTICE_FREE) begin
                                acc_next   = 1'b1;
                                state_next = ubf_pkg::ST_NOTICE;
                            end
                        end
                        ubf_pkg::OP_HOST_WR: begin
                            if (tx_stat.free != '0) begin
                                tx_ctrl.wr_en = 1'b1;
                                acc_next      = 1'b1;
                            end
                            tx_on_next = 1'b1;
                        end
                        ubf_pkg::OP_HOST_RD: begin
                            if (rx_stat.used != '0) begin
                                rx_ctrl.rd_en = 1'b1;
                                pop_next      = 1'b1;
                            end
                        end
                        default: begin
                            if (tx_stat.used != '0) begin
                                tx_ctrl.rd_en = 1'b1;
                                pop_next      = 1'b1;
                            end else begin
                                tx_on_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            ubf_pkg::ST_NOTICE: begin
                // one notice byte per cycle through the receive write port
                rx_ctrl.wr_en   = 1'b1;
                rx_ctrl.wr_data = ubf_pkg::notice_byte(cnt_reg);
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == NOTICE_END) begin
                    state_next = ubf_pkg::ST_DONE;
                end
            end
            ubf_pkg::ST_DONE: begin
                m_data_next.data_out   = '0;
                if (pop_reg) begin
                    m_data_next.data_out = (op_reg == ubf_pkg::OP_HOST_RD) ?
                                           rx_stat.rd_data : tx_stat.rd_data;
                end
                m_data_next.data_valid = pop_reg;
                m_data_next.accepted   = acc_reg;
                m_data_next.last_out   = last_reg;
                m_data_next.tx_enabled = tx_on_reg;
                m_data_next.rx_used    = ubf_pkg::COUNT_W'(rx_stat.used);
                m_data_next.tx_free    = ubf_pkg::COUNT_W'(tx_stat.free);
                m_valid_next           = 1'b1;
                state_next             = ubf_pkg::ST_IDLE;
            end
            default: begin
                state_next = ubf_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ubf_pkg::ST_IDLE;
            tx_on_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            tx_on_reg   <= tx_on_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        last_reg   <= last_next;
        acc_reg    <= acc_next;
        pop_reg    <= pop_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    // a full receive ring is never written
    a_rx_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        (rx_stat.free == '0) |-> !rx_ctrl.wr_en)
        else $error("receive ring written while full");

    // the transmit ring is never popped when empty
    a_tx_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_ctrl.rd_en |-> (tx_stat.used != '0))
        else $error("transmit ring popped while empty");

    // one item at a time: no second transfer in right after one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in progress");

    // the notice write ends with the receive ring full
    a_notice_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ubf_pkg::ST_NOTICE && cnt_reg == NOTICE_END)
        |=> (rx_stat.free == '0))
        else $error("overflow notice did not fill the receive ring");
`endif

endmodule

`default_nettype wire
